>>> sv/ffha_pkg.sv
// types and constants shared by the first-fit heap allocator modules
`default_nettype none
package ffha_pkg;

  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [ADDR_W-1:0] HDR    = ADDR_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HEAP_BYTES_RESET = 16'd4096;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_addr;
    logic [1:0]        status;
  } out_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              is_free;
  } seg_t;

  typedef struct packed {
    logic              init;
    logic [ADDR_W-1:0] init_size;
    logic              tok_start;
    logic              advance;
    logic              is_free_op;
    logic [ADDR_W-1:0] want;
    logic [ADDR_W-1:0] addr;
    logic              mark_used;
    logic              mark_free;
    logic [ADDR_W-1:0] new_size;
    logic              shift;
    seg_t              tail;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_UPDATE,
    S_RESULT
  } fsm_t;

endpackage
`default_nettype wire

>>> sv/ffha_cell.sv
// one segment slot of the allocator chain
`default_nettype none
module ffha_cell
  import ffha_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire logic      is_head,
  input  wire logic      tok_in,
  input  wire logic      left_tok,
  input  wire seg_t      left_seg,
  output logic           token,
  output seg_t           seg,
  output logic           hit
);

  logic token_r, token_nxt;
  logic visited_r, visited_nxt;
  seg_t seg_r, seg_nxt;
  logic [ADDR_W-1:0] payload;

  always_comb begin
    token_nxt   = (cmd.tok_start || cmd.advance) ? tok_in : token_r;
    visited_nxt = cmd.tok_start ? 1'b0 : (cmd.advance ? (visited_r | token_r) : visited_r);
    seg_nxt     = seg_r;
    if (cmd.init && is_head) begin
      seg_nxt.start   = '0;
      seg_nxt.size    = cmd.init_size;
      seg_nxt.is_free = 1'b1;
    end else if (cmd.shift && !visited_r && !token_r) begin
      // slide right by one, tail of the split lands next to the chosen slot
      seg_nxt = left_tok ? cmd.tail : left_seg;
    end else if (token_r && cmd.mark_used) begin
      seg_nxt.size    = cmd.new_size;
      seg_nxt.is_free = 1'b0;
    end else if (token_r && cmd.mark_free) begin
      seg_nxt.is_free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r   <= 1'b0;
      visited_r <= 1'b0;
    end else begin
      token_r   <= token_nxt;
      visited_r <= visited_nxt;
    end
    seg_r <= seg_nxt;
  end

  assign payload = seg_r.start + HDR;
  assign token   = token_r;
  assign seg     = seg_r;
  assign hit     = token_r && (cmd.is_free_op ? (payload == cmd.addr)
                                              : (seg_r.is_free && seg_r.size >= cmd.want));

endmodule
`default_nettype wire

>>> sv/first_fit_heap_allocator_unit.sv
// first-fit heap allocator: control sequencer over a chain of segment cells
// the scan steps right from the head and stops at the first matching segment or after every segment in use
// the first allocate after reset also builds the table
// throughput: one item at a time, the scan token moves one cell per cycle
// reset: table empty and not built, heap size back to 4096, no result pending
`default_nettype none
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  fsm_t              state_r, state_nxt;
  in_beat_t          op_r, op_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              ready_r, ready_nxt;
  seg_t              hit_seg_r, hit_seg_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  status_t           res_status_r, res_status_nxt;
  out_beat_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] heap_bytes_r;

  cell_cmd_t cmd;
  logic [MAX_SEGMENTS-1:0] cell_tok, cell_hit;
  seg_t                    cell_seg [MAX_SEGMENTS];
  seg_t                    hit_seg;
  logic                    any_hit;
  logic [ADDR_W-1:0]       rem;
  logic                    split;

  // config port, the heap size is the only register and every address maps to it; pready tied high
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {16'h0, heap_bytes_r} | (32'(cfg_paddr) & 32'h0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= HEAP_BYTES_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      heap_bytes_r <= cfg_pwdata[ADDR_W-1:0];
    end
  end

  // segment chain, token enters at the head and steps right
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      ffha_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .is_head  (1'b1),
        .tok_in   (cmd.tok_start),
        .left_tok (1'b0),
        .left_seg ('0),
        .token    (cell_tok[i]),
        .seg      (cell_seg[i]),
        .hit      (cell_hit[i])
      );
    end else begin : g_body
      ffha_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .is_head  (1'b0),
        .tok_in   (cell_tok[i-1] && !cmd.tok_start),
        .left_tok (cell_tok[i-1]),
        .left_seg (cell_seg[i-1]),
        .token    (cell_tok[i]),
        .seg      (cell_seg[i]),
        .hit      (cell_hit[i])
      );
    end
  end

  // token is one-hot while scanning, so an and-or picks the current slot
  always_comb begin
    hit_seg = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      hit_seg = hit_seg | (cell_tok[i] ? cell_seg[i] : seg_t'('0));
    end
  end
  assign any_hit = |cell_hit;

  assign rem   = hit_seg_r.size - op_r.req_size;
  assign split = (rem > HDR) && (count_r < CNT_MAX);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    ready_nxt      = ready_r;
    hit_seg_nxt    = hit_seg_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;

    cmd            = '0;
    cmd.is_free_op = (op_r.action == ACT_FREE);
    cmd.want       = op_r.req_size;
    cmd.addr       = op_r.free_addr;
    cmd.init_size  = (heap_bytes_r > HDR) ? (heap_bytes_r - HDR) : '0;
    cmd.new_size   = split ? op_r.req_size : hit_seg_r.size;
    cmd.tail.start = hit_seg_r.start + HDR + op_r.req_size;
    cmd.tail.size  = rem - HDR;
    cmd.tail.is_free = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt       = in_data;
          res_addr_nxt = '0;
          if (in_data.action == ACT_ALLOC && in_data.req_size == '0) begin
            res_status_nxt = ST_ZERO;
            state_nxt      = S_RESULT;
          end else if (!ready_r && in_data.action == ACT_FREE) begin
            res_status_nxt = ST_UNKNOWN;
            state_nxt      = S_RESULT;
          end else if (!ready_r) begin
            state_nxt = S_INIT;
          end else begin
            cmd.tok_start = 1'b1;
            k_nxt         = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_INIT: begin
        // whole heap as one free segment, scan starts in the same cycle
        cmd.init      = 1'b1;
        cmd.tok_start = 1'b1;
        count_nxt     = CNT_W'(1);
        ready_nxt     = 1'b1;
        k_nxt         = '0;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (k_r == count_r) begin
          res_status_nxt = (op_r.action == ACT_FREE) ? ST_UNKNOWN : ST_NOFIT;
          state_nxt      = S_RESULT;
        end else if (any_hit) begin
          hit_seg_nxt = hit_seg;
          state_nxt   = S_UPDATE;
        end else begin
          cmd.advance = 1'b1;
          k_nxt       = k_r + CNT_W'(1);
        end
      end
      S_UPDATE: begin
        res_status_nxt = ST_OK;
        if (op_r.action == ACT_FREE) begin
          cmd.mark_free = 1'b1;
        end else begin
          cmd.mark_used = 1'b1;
          cmd.shift     = split;
          res_addr_nxt  = hit_seg_r.start + HDR;
          if (split) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.payload_addr = res_addr_r;
          out_nxt.status       = res_status_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
    op_r         <= op_nxt;
    hit_seg_r    <= hit_seg_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
